[hw/rtl/gww_pkg.sv]
// types, constants and codes shared by the greedy word wrap block
`default_nettype none

package gww_pkg;

	localparam int NUM_GLYPHS_DEF = 95;
	localparam int FIRST_CODE_DEF = 32;

	localparam int CODE_W      = 8;
	localparam int ADV_IN_W    = 16;
	localparam int SCALE_W     = 10;
	localparam int WIDTH_W     = 24;
	localparam int LEN_W       = 16;
	localparam int SCALE_SHIFT = 4;
	localparam int PROD_W      = ADV_IN_W + SCALE_W;
	localparam int ADV_W       = PROD_W - SCALE_SHIFT;
	localparam int CFG_INDEX_W = 2;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [CODE_W-1:0]  SPACE_CODE = CODE_W'(32);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX  = '1;
	localparam logic [LEN_W-1:0]   LEN_MAX    = '1;

	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = WIDTH_MAX;
	localparam logic [SCALE_W-1:0] GLYPH_SCALE_RST = SCALE_W'(16);

	// request kinds
	localparam logic REQ_TEXT = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_SCALE = CFG_INDEX_W'(1);

	typedef struct packed {
		logic                req_type;
		logic [CODE_W-1:0]   char_code;
		logic [ADV_IN_W-1:0] advance_value;
		logic                last_char;
	} gww_in_t;

	typedef struct packed {
		logic [LEN_W-1:0]   line_length;
		logic [WIDTH_W-1:0] line_width;
		logic               final_line;
	} gww_out_t;

	// scaled glyph handed from the lookup stage to the line tracker
	typedef struct packed {
		logic             valid;
		logic             is_space;
		logic             last;
		logic [ADV_W-1:0] adv;
	} gww_glyph_t;

	// up to two finished lines per character
	typedef struct packed {
		logic [1:0] cnt;
		gww_out_t   first;
		gww_out_t   second;
	} gww_push_t;

endpackage

`default_nettype wire

[hw/rtl/greedy_word_wrap_unit.sv]
// top level of the greedy word wrap block
//
// Takes one word per cycle while the result queue has room: text characters and
// advance table loads share the input channel. A character is looked up in the advance
// table ram, scaled by one 26-bit multiply, and then added to the running line width
// in a registered state update; the table read and scaled-advance registers lie between
// acceptance and the result queue write. A character yields zero, one or two
// result words (a break, a final line, or both). The four-entry result queue sets the
// rate: input is taken while at least two slots are free, so with the output side
// ready the block sustains one character per cycle. Configuration writes are taken in
// any cycle and are meant for idle times.
`default_nettype none

module greedy_word_wrap_unit
	import gww_pkg::*;
#(
	parameter int NUM_GLYPHS = NUM_GLYPHS_DEF,
	parameter int FIRST_CODE = FIRST_CODE_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire gww_in_t                in_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output gww_out_t                    out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [WIDTH_W-1:0]     cfg_data
);

	logic               en;
	logic               take;
	logic [WIDTH_W-1:0] max_width_q;
	logic [SCALE_W-1:0] scale_q;
	gww_glyph_t         glyph;
	gww_push_t          push;

	assign cfg_ready = 1'b1;
	assign in_ready  = en;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_width_q <= MAX_WIDTH_RST;
			scale_q     <= GLYPH_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_WIDTH: begin
					max_width_q <= cfg_data;
				end
				CFG_GLYPH_SCALE: begin
					scale_q <= cfg_data[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	gww_scale #(
		.NUM_GLYPHS(NUM_GLYPHS),
		.FIRST_CODE(FIRST_CODE)
	) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take       (take),
		.in_data    (in_data),
		.glyph_scale(scale_q),
		.glyph      (glyph)
	);

	gww_line u_line (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.glyph         (glyph),
		.max_line_width(max_width_q),
		.push          (push)
	);

	gww_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (en),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

[hw/rtl/gww_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module gww_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 95,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gww_scale.sv]
// advance table, lookup register and scaling multiply
`default_nettype none

module gww_scale
	import gww_pkg::*;
#(
	parameter int NUM_GLYPHS = NUM_GLYPHS_DEF,
	parameter int FIRST_CODE = FIRST_CODE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               take,
	input  wire gww_in_t            in_data,
	input  wire logic [SCALE_W-1:0] glyph_scale,
	output gww_glyph_t              glyph
);

	localparam int IDX_W = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;

	logic [CODE_W:0]       diff;
	logic                  in_table;
	logic [IDX_W-1:0]      idx;
	logic                  is_text;
	logic [NUM_GLYPHS-1:0] loaded_q;
	logic [ADV_IN_W-1:0]   rdata;
	logic                  text_s1;
	logic                  space_s1;
	logic                  last_s1;
	logic                  hit_s1;
	logic [PROD_W-1:0]     prod;
	logic [ADV_W-1:0]      adv;
	logic                  valid_s2;
	logic                  space_s2;
	logic                  last_s2;
	logic [ADV_W-1:0]      adv_s2;

	assign diff     = {1'b0, in_data.char_code} - (CODE_W+1)'(FIRST_CODE);
	assign in_table = !diff[CODE_W] && (diff < (CODE_W+1)'(NUM_GLYPHS));
	assign idx      = diff[IDX_W-1:0];
	assign is_text  = in_data.req_type == REQ_TEXT;

	gww_ram #(
		.WIDTH(ADV_IN_W),
		.DEPTH(NUM_GLYPHS)
	) u_table (
		.clk  (clk),
		.we   (take && !is_text && in_table),
		.waddr(idx),
		.wdata(in_data.advance_value),
		.re   (take && is_text && in_table),
		.raddr(idx),
		.rdata(rdata)
	);

	// entries never loaded read as zero advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			text_s1  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take && !is_text && in_table) begin
				loaded_q[idx] <= 1'b1;
			end
			if (en) begin
				text_s1  <= take && is_text;
				valid_s2 <= text_s1;
			end
		end
	end

	assign prod = PROD_W'(rdata) * PROD_W'(glyph_scale);
	assign adv  = hit_s1 ? prod[PROD_W-1:SCALE_SHIFT] : '0;

	always_ff @(posedge clk) begin
		if (take) begin
			space_s1 <= in_data.char_code == SPACE_CODE;
			last_s1  <= in_data.last_char;
			hit_s1   <= in_table && loaded_q[idx];
		end
		if (en) begin
			space_s2 <= space_s1;
			last_s2  <= last_s1;
			adv_s2   <= adv;
		end
	end

	assign glyph = '{valid: valid_s2, is_space: space_s2, last: last_s2, adv: adv_s2};

endmodule

`default_nettype wire

[hw/rtl/gww_line.sv]
// running line width, space tracking and break decision
`default_nettype none

module gww_line
	import gww_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire gww_glyph_t         glyph,
	input  wire logic [WIDTH_W-1:0] max_line_width,
	output gww_push_t               push
);

	logic [WIDTH_W-1:0] run_q, before_q, after_q;
	logic [LEN_W-1:0]   count_q, space_pos_q;
	logic               no_space_q;

	logic [WIDTH_W:0]   run_sum, after_sum;
	logic [WIDTH_W-1:0] new_w, after_add;
	logic               sp_none;
	logic [LEN_W-1:0]   sp_pos;
	logic [WIDTH_W-1:0] before_eff;
	logic               brk;
	logic               fire;
	logic [LEN_W-1:0]   len_brk;
	logic [WIDTH_W-1:0] run_n, before_n, after_n;
	logic [LEN_W-1:0]   count_n, space_pos_n;
	logic               no_space_n;

	assign run_sum   = {1'b0, run_q} + (WIDTH_W+1)'(glyph.adv);
	assign after_sum = {1'b0, after_q} + (WIDTH_W+1)'(glyph.adv);
	assign new_w     = run_sum[WIDTH_W] ? WIDTH_MAX : run_sum[WIDTH_W-1:0];
	assign after_add = after_sum[WIDTH_W] ? WIDTH_MAX : after_sum[WIDTH_W-1:0];
	assign fire      = en && glyph.valid;

	always_comb begin
		sp_none    = glyph.is_space ? 1'b0 : no_space_q;
		sp_pos     = glyph.is_space ? count_q : space_pos_q;
		before_eff = glyph.is_space ? run_q : before_q;
		// a space at the line's first position never allows a break
		brk        = (new_w > max_line_width) && !sp_none && (sp_pos != '0);
		len_brk    = (sp_pos == LEN_MAX) ? LEN_MAX : sp_pos + LEN_W'(1);
		if (brk) begin
			run_n       = glyph.is_space ? '0 : after_add;
			count_n     = glyph.is_space ? '0 : count_q - sp_pos;
			after_n     = run_n;
			before_n    = '0;
			no_space_n  = 1'b1;
			space_pos_n = '0;
		end else begin
			run_n       = new_w;
			count_n     = (count_q == LEN_MAX) ? LEN_MAX : count_q + LEN_W'(1);
			after_n     = glyph.is_space ? '0 : after_add;
			before_n    = before_eff;
			no_space_n  = sp_none;
			space_pos_n = sp_pos;
		end
		push.first.line_length  = brk ? len_brk : count_n;
		push.first.line_width   = brk ? before_eff : run_n;
		push.first.final_line   = !brk;
		push.second.line_length = count_n;
		push.second.line_width  = run_n;
		push.second.final_line  = 1'b1;
		push.cnt = fire ? ({1'b0, brk} + {1'b0, glyph.last}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			before_q    <= '0;
			after_q     <= '0;
			count_q     <= '0;
			space_pos_q <= '0;
			no_space_q  <= 1'b1;
		end else if (fire) begin
			if (glyph.last) begin
				run_q       <= '0;
				before_q    <= '0;
				after_q     <= '0;
				count_q     <= '0;
				space_pos_q <= '0;
				no_space_q  <= 1'b1;
			end else begin
				run_q       <= run_n;
				before_q    <= before_n;
				after_q     <= after_n;
				count_q     <= count_n;
				space_pos_q <= space_pos_n;
				no_space_q  <= no_space_n;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gww_fifo.sv]
// result queue taking up to two words per cycle
`default_nettype none

module gww_fifo
	import gww_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire gww_push_t push,
	output logic           room,
	output logic           out_valid,
	input  wire logic      out_ready,
	output gww_out_t       out_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	gww_out_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for the worst case of two words from the next character
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[PTR_W'(wr_q + PTR_W'(1))] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PTR_W'(wr_q + PTR_W'(push.cnt));
			if (pop) begin
				rd_q <= PTR_W'(rd_q + PTR_W'(1));
			end
			count_q <= CNT_W'(count_q + CNT_W'(push.cnt) - CNT_W'(pop));
		end
	end

endmodule

`default_nettype wire
